// ===== design/complex_abs1_argmax_assert.svh =====
// Assertion macros for the complex 1-norm argmax block.
`ifndef COMPLEX_ABS1_ARGMAX_ASSERT_SVH
`define COMPLEX_ABS1_ARGMAX_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define CA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication.
`define CA_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== design/cabs_pkg.sv =====
// Shared types, constants and a float helper for the complex 1-norm argmax block.
`timescale 1ns / 1ps
package cabs_pkg;
    localparam int INDEX_BITS = 31;
    localparam logic [INDEX_BITS-1:0] POS_LIMIT = {{(INDEX_BITS-1){1'b1}}, 1'b0};
    localparam int QDEPTH = 4;
    localparam int QPTR = $clog2(QDEPTH);

    typedef struct packed {
        logic [31:0] real_bits;
        logic [31:0] imag_bits;
        logic        last;
    } t_in_req;

    typedef struct packed {
        logic [INDEX_BITS-1:0] index_one_based;
        logic [31:0]           max_modulus_bits;
        logic                  found_valid;
    } t_out_req;

    // Queue entry between front and back: modulus, its position, last flag.
    typedef struct packed {
        logic [31:0]           modulus;
        logic [INDEX_BITS-1:0] pos;
        logic                  last;
    } t_q_req;

    // Positive binary32 add, round to nearest even. Inputs have sign bit clear.
    function automatic logic [31:0] fadd_pos(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x, y, res;
        logic [7:0]  ex, ey, d;
        logic [23:0] mx, my;
        logic [26:0] sx, sy;
        logic [27:0] s;
        logic        st;
        logic [7:0]  e;
        logic [24:0] m;
        logic        g, r, k;
        if (b[30:0] > a[30:0]) begin x = b; y = a; end else begin x = a; y = b; end
        ex = x[30:23]; ey = y[30:23];
        res = 32'd0;
        if (ex == 8'hFF) begin
            if (x[22:0] != 0) res = 32'h7FC00000;
            else res = 32'h7F800000;
        end else begin
            mx = {(ex != 0), x[22:0]};
            my = {(ey != 0), y[22:0]};
            if (ex == 0) ex = 8'd1;
            if (ey == 0) ey = 8'd1;
            d = ex - ey;
            sx = {mx, 3'b000};
            if (d > 8'd26) begin
                sy = {26'd0, (my != 0)};
            end else begin
                sy = {my, 3'b000} >> d;
                st = (({my, 3'b000} & ((27'd1 << d) - 27'd1)) != 0);
                sy[0] = sy[0] | st;
            end
            s = {1'b0, sx} + {1'b0, sy};
            e = ex;
            if (s[27]) begin
                s = {1'b0, s[27:2], s[1] | s[0]};
                e = e + 8'd1;
            end
            // s[26] set or value subnormal (e==1, no leading one)
            g = s[2]; r = s[1]; k = s[0];
            m = {1'b0, s[26:3]};
            if (g && (r || k || m[0])) m = m + 25'd1;
            if (m[24]) begin
                m = m >> 1;
                e = e + 8'd1;
            end
            if (e == 8'hFF) res = 32'h7F800000;
            else if (!m[23]) res = {1'b0, 8'd0, m[22:0]};
            else res = {1'b0, e, m[22:0]};
        end
        return res;
    endfunction
endpackage

// ===== design/cabs_front.sv =====
// Front: takes elements, forms the 1-norm modulus and numbers positions.
`timescale 1ns / 1ps
module cabs_front import cabs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_in_req i_req,
    output logic    o_valid,
    input  logic    i_ready,
    output t_q_req  o_req
);
    logic                  r_valid, n_valid;
    t_q_req                r_req;
    logic [INDEX_BITS-1:0] r_pos, n_pos;
    logic                  w_take;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_comb begin
        n_valid = r_valid;
        if (i_ready) n_valid = 1'b0;
        if (w_take) n_valid = 1'b1;
        n_pos = r_pos;
        if (w_take) begin
            if (i_req.last) n_pos = '0;
            else if (r_pos < POS_LIMIT) n_pos = r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_valid <= n_valid;
            r_pos   <= n_pos;
        end
        if (w_take) begin
            r_req.modulus <= fadd_pos({1'b0, i_req.real_bits[30:0]},
                                      {1'b0, i_req.imag_bits[30:0]});
            r_req.pos     <= r_pos;
            r_req.last    <= i_req.last;
        end
    end
endmodule

// ===== design/cabs_queue.sv =====
// Short FIFO between the front and back stages.
`timescale 1ns / 1ps
module cabs_queue import cabs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_q_req i_req,
    output logic   o_valid,
    input  logic   i_ready,
    output t_q_req o_req
);
    t_q_req          r_mem [QDEPTH];
    logic [QPTR-1:0] r_wr, r_rd;
    logic [QPTR:0]   r_cnt;
    logic            w_push, w_pop;

    assign o_ready = (r_cnt != (QPTR+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QPTR+1)'(w_push) - (QPTR+1)'(w_pop);
        end
        if (w_push) r_mem[r_wr] <= i_req;
    end
endmodule

// ===== design/cabs_back.sv =====
// Back: compares moduli, tracks the best and emits the result on last.
`timescale 1ns / 1ps
module cabs_back import cabs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_q_req   i_req,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out_req o_req
);
    logic [31:0]           r_best, n_best;
    logic [INDEX_BITS-1:0] r_bpos, n_bpos;
    logic                  r_have, n_have;
    logic                  r_ovalid;
    t_out_req              r_out;
    logic                  w_take, w_nan, w_upd;

    assign o_ready = !r_ovalid || i_ready;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_req   = r_out;
    assign w_nan   = (i_req.modulus[30:23] == 8'hFF) && (i_req.modulus[22:0] != 0);
    // Both positive: bit-pattern order equals value order.
    assign w_upd   = !w_nan && (!r_have || (i_req.modulus[30:0] > r_best[30:0]));

    always_comb begin
        n_best = w_upd ? i_req.modulus : r_best;
        n_bpos = w_upd ? i_req.pos : r_bpos;
        n_have = r_have || w_upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_best   <= '0;
            r_bpos   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ready) r_ovalid <= 1'b0;
            if (w_take) begin
                if (i_req.last) begin
                    r_ovalid <= 1'b1;
                    r_have   <= 1'b0;
                    r_best   <= '0;
                    r_bpos   <= '0;
                end else begin
                    r_have <= n_have;
                    r_best <= n_best;
                    r_bpos <= n_bpos;
                end
            end
        end
        if (w_take && i_req.last) begin
            r_out.index_one_based  <= n_have ? n_bpos + 1'b1 : INDEX_BITS'(1);
            r_out.max_modulus_bits <= n_have ? n_best : 32'd0;
            r_out.found_valid      <= n_have;
        end
    end
endmodule

// ===== design/complex_abs1_argmax.sv =====
// Path from an accepted element to a valid result runs through three
// register stages (modulus, queue entry, result register).
// Throughput: one element per cycle while the receiver does not stall; the binary32
// adder and the compare are each one registered stage.
// Reset: synchronous active-low i_rst_n clears the best, the position
// counter, the queue and all valid flags. Result only on a last element.
`timescale 1ns / 1ps
`include "complex_abs1_argmax_assert.svh"
module complex_abs1_argmax import cabs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_req  i_req,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out_req o_req
);
    // front -> queue
    logic   w_fv, w_fr;
    t_q_req w_freq;
    // queue -> back
    logic   w_qv, w_qr;
    t_q_req w_qreq;

    // Front stage: modulus add and position numbering.
    cabs_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_valid), .o_ready(o_ready), .i_req(i_req),
        .o_valid(w_fv), .i_ready(w_fr), .o_req(w_freq)
    );

    // Decoupling queue.
    cabs_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_fv), .o_ready(w_fr), .i_req(w_freq),
        .o_valid(w_qv), .i_ready(w_qr), .o_req(w_qreq)
    );

    // Back stage: running argmax and result register.
    cabs_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_qv), .o_ready(w_qr), .i_req(w_qreq),
        .o_valid(o_valid), .i_ready(i_ready), .o_req(o_req)
    );

    // A result with no valid element reports index 1 and zero modulus.
    `CA_ASSERT_IMP(a_none, i_clk, i_rst_n, o_valid && !o_req.found_valid,
        o_req.index_one_based == INDEX_BITS'(1) && o_req.max_modulus_bits == 32'd0)
    // Reported modulus is never NaN nor negative.
    `CA_ASSERT_IMP(a_mod, i_clk, i_rst_n, o_valid,
        !o_req.max_modulus_bits[31] && !(o_req.max_modulus_bits[30:23] == 8'hFF
        && o_req.max_modulus_bits[22:0] != 23'd0))
    // Index is always 1-based.
    `CA_ASSERT_IMP(a_idx, i_clk, i_rst_n, o_valid, o_req.index_one_based != '0)
endmodule

// ===== dv/complex_abs1_argmax_test.sv =====
// Self-checking testbench for the complex 1-norm argmax block.
`timescale 1ns / 1ps
module complex_abs1_argmax_test;
    import cabs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int LONG_HOLD      = 300;
    localparam logic [31:0] QNAN  = 32'h7FC00000;
    localparam logic [31:0] PINF  = 32'h7F800000;
    localparam logic [31:0] ONE   = 32'h3F800000;
    localparam logic [31:0] NEG   = 32'h80000000;

    // One row of the directed table: request, and a typed result where obvious.
    typedef struct {
        t_in_req  req;
        bit       typed;
        t_out_req want;
    } t_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_in_req  i_req;
    logic     o_valid;
    logic     i_ready;
    t_out_req o_req;

    // Typed result travels alongside the request it belongs to.
    bit       cur_typed;
    t_out_req cur_want;

    // Predictor state: a copy of the block's running best.
    logic [31:0]           best_mod;
    logic [INDEX_BITS-1:0] best_pos;
    bit                    have_best;
    logic [INDEX_BITS-1:0] elem_pos;

    t_out_req argmax_q[$];
    int fail_cnt;
    int req_cnt;
    int res_cnt;
    int nan_cnt;
    int idle_cycles;
    int send_pct;
    int stall_pct;
    int hold_left;
    bit timed_out;

    t_row rows[$];

    complex_abs1_argmax i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_req   (o_req)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Sum of two non-negative binary32 values, round to nearest even.
    // Operands are aligned into a 57-bit field with 32 guard bits plus sticky.
    function automatic logic [31:0] abs1_sum(input logic [31:0] a, input logic [31:0] b);
        logic [30:0] hi, lo;
        int          eh, el, shift, e;
        logic [56:0] acc, addend;
        logic [24:0] mant;
        bit          guard, rest;
        hi = (a[30:0] >= b[30:0]) ? a[30:0] : b[30:0];
        lo = (a[30:0] >= b[30:0]) ? b[30:0] : a[30:0];
        if (hi[30:23] == 8'hFF) begin
            return (hi[22:0] != 0) ? QNAN : PINF;
        end
        eh = (hi[30:23] == 0) ? 1 : hi[30:23];
        el = (lo[30:23] == 0) ? 1 : lo[30:23];
        shift = eh - el;
        acc = {1'b0, (hi[30:23] != 0), hi[22:0], 32'd0};
        addend = {1'b0, (lo[30:23] != 0), lo[22:0], 32'd0};
        if (shift >= 57) begin
            addend = (addend != 0) ? 57'd1 : 57'd0;
        end else if (shift > 0) begin
            // keep whatever falls off as a sticky bit
            rest = ((addend & ((57'd1 << shift) - 57'd1)) != 0);
            addend = (addend >> shift) | {56'd0, rest};
        end
        acc = acc + addend;
        e = eh;
        if (acc[56]) begin
            acc = {1'b0, acc[56:2], acc[1] | acc[0]};
            e = e + 1;
        end
        mant = {1'b0, acc[55:32]};
        guard = acc[31];
        rest = (acc[30:0] != 0);
        if (guard && (rest || mant[0])) mant = mant + 25'd1;
        if (mant[24]) begin
            mant = mant >> 1;
            e = e + 1;
        end
        if (e >= 255) return PINF;
        if (!mant[23]) return {9'd0, mant[22:0]};
        return {1'b0, e[7:0], mant[22:0]};
    endfunction

    // Advance the running argmax by one element; returns 1 when a result is due.
    function automatic bit argmax_step(input t_in_req r, output t_out_req res);
        logic [31:0] modulus;
        modulus = abs1_sum({1'b0, r.real_bits[30:0]}, {1'b0, r.imag_bits[30:0]});
        res = '0;
        if (modulus[30:23] == 8'hFF && modulus[22:0] != 0) begin
            nan_cnt++;
        end else if (!have_best || modulus[30:0] > best_mod[30:0]) begin
            // both sides are non-negative, so bit order is numeric order
            best_mod = modulus;
            best_pos = elem_pos;
            have_best = 1'b1;
        end
        if (elem_pos < POS_LIMIT) elem_pos = elem_pos + 1'b1;
        if (!r.last) return 1'b0;
        if (have_best) begin
            res.index_one_based = best_pos + 1'b1;
            res.max_modulus_bits = best_mod;
            res.found_valid = 1'b1;
        end else begin
            res.index_one_based = INDEX_BITS'(1);
        end
        best_mod = '0;
        best_pos = '0;
        have_best = 1'b0;
        elem_pos = '0;
        return 1'b1;
    endfunction

    // Requests are seen mid-cycle; they are taken at the next rising edge.
    always @(negedge i_clk) begin
        t_out_req res;
        if (i_rst_n && i_valid && o_ready) begin
            req_cnt++;
            if (argmax_step(i_req, res)) argmax_q.push_back(cur_typed ? cur_want : res);
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (argmax_q.size() == 0) begin
                $display("%0t: unexpected result idx=%0d mod=%h found=%b", $time,
                    o_req.index_one_based, o_req.max_modulus_bits, o_req.found_valid);
                fail_cnt++;
            end else begin
                res = argmax_q.pop_front();
                res_cnt++;
                if (o_req.index_one_based !== res.index_one_based) begin
                    $display("%0t: index expected %0d actual %0d", $time,
                        res.index_one_based, o_req.index_one_based);
                    fail_cnt++;
                end
                if (o_req.max_modulus_bits !== res.max_modulus_bits) begin
                    $display("%0t: modulus expected %h actual %h", $time,
                        res.max_modulus_bits, o_req.max_modulus_bits);
                    fail_cnt++;
                end
                if (o_req.found_valid !== res.found_valid) begin
                    $display("%0t: found expected %b actual %b", $time,
                        res.found_valid, o_req.found_valid);
                    fail_cnt++;
                end
            end
        end
    end

    // Receiver: random stalls, or one long hold-off to back the block up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: cycles in which nothing moves on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (timed_out);
        $display("%0t: watchdog expired, %0d results outstanding", $time, argmax_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    // Hand one request to the block and hold it until taken.
    task automatic offer(input t_in_req r, input bit typed, input t_out_req want);
        int gap;
        gap = ($urandom_range(99) < send_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req <= r;
        cur_typed <= typed;
        cur_want <= want;
        i_valid <= 1'b1;
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
    endtask

    // Random part of a complex value, weighted toward special encodings.
    function automatic logic [31:0] pick_part(input logic [31:0] prev);
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(11))
            0: v[30:0] = {8'hFF, 1'b1, v[21:0]};                 // NaN
            1: v[30:0] = {8'hFF, 23'd0};                          // infinity
            2: v[30:0] = '0;                                      // zero
            3: v[30:23] = 8'h00;                                  // subnormal
            4: v[30:0] = prev[30:0];                              // tie with previous
            5: v[30:0] = prev[30:0] + 31'($urandom_range(0, 3));  // near tie
            6: v[30:23] = 8'hFE;                                  // near overflow
            7, 8, 9: v[30:23] = 8'd120 + 8'($urandom_range(0, 15)); // close exponents
            default: ;
        endcase
        return v;
    endfunction

    // Stream random vectors, mostly short, until the item budget is spent.
    task automatic run_vectors(input int budget, input bit pressure);
        t_in_req  r;
        t_out_req none;
        logic [31:0] prev;
        int len;
        none = '0;
        prev = ONE;
        while (budget > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                r.real_bits = pick_part(prev);
                r.imag_bits = pick_part(r.real_bits);
                r.last = (k == len - 1);
                prev = r.imag_bits;
                if (pressure && budget == 100) hold_left = LONG_HOLD;
                offer(r, 1'b0, none);
                budget--;
            end
        end
    endtask

    function automatic t_row mk(input logic [31:0] re, input logic [31:0] im, input bit last,
                                input bit typed, input int idx, input logic [31:0] modv,
                                input bit found);
        t_row w;
        w.req = '{real_bits: re, imag_bits: im, last: last};
        w.typed = typed;
        w.want = '{index_one_based: INDEX_BITS'(idx), max_modulus_bits: modv,
                   found_valid: found};
        return w;
    endfunction

    initial begin
        fail_cnt = 0;
        req_cnt = 0;
        res_cnt = 0;
        nan_cnt = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        send_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        best_mod = '0;
        best_pos = '0;
        have_best = 1'b0;
        elem_pos = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_req = '0;
        cur_typed = 1'b0;
        cur_want = '0;

        // single-element vectors with results that follow from the encoding
        rows.push_back(mk(32'h0, 32'h0, 1, 1, 1, 32'h0, 1));
        rows.push_back(mk(NEG, NEG, 1, 1, 1, 32'h0, 1));             // signed zeros
        rows.push_back(mk(QNAN, 32'h0, 1, 1, 1, 32'h0, 0));          // NaN part
        rows.push_back(mk(32'hFFFFFFFF, ONE, 1, 1, 1, 32'h0, 0));
        rows.push_back(mk(PINF, NEG, 1, 1, 1, PINF, 1));
        rows.push_back(mk(PINF, 32'hFF800000, 1, 1, 1, PINF, 1));
        rows.push_back(mk(32'h7F7FFFFF, 32'hFF7FFFFF, 1, 1, 1, PINF, 1)); // overflow
        rows.push_back(mk(32'h00000001, 32'h80000001, 1, 1, 1, 32'h2, 1));
        rows.push_back(mk(PINF, QNAN, 1, 1, 1, 32'h0, 0));
        // all-NaN vector
        rows.push_back(mk(QNAN, ONE, 0, 0, 0, 0, 0));
        rows.push_back(mk(32'h7F800001, 32'h0, 0, 0, 0, 0, 0));
        rows.push_back(mk(32'hFFC00000, 32'hFFFFFFFF, 1, 1, 1, 32'h0, 0));
        // first maximum wins a tie, NaN keeps its slot
        rows.push_back(mk(ONE, 32'h0, 0, 0, 0, 0, 0));
        rows.push_back(mk(32'h40000000, 32'h0, 0, 0, 0, 0, 0));
        rows.push_back(mk(32'h0, 32'hC0000000, 0, 0, 0, 0, 0));
        rows.push_back(mk(QNAN, QNAN, 0, 0, 0, 0, 0));
        rows.push_back(mk(32'hBF800000, 32'h0, 1, 0, 0, 0, 0));
        // first infinity wins
        rows.push_back(mk(ONE, ONE, 0, 0, 0, 0, 0));
        rows.push_back(mk(32'h0, PINF, 0, 0, 0, 0, 0));
        rows.push_back(mk(PINF, 32'h0, 1, 0, 0, 0, 0));
        // rounding ties to even, and a rounding carry
        rows.push_back(mk(ONE, 32'h33800000, 1, 0, 0, 0, 0));
        rows.push_back(mk(32'h3F800001, 32'h33800000, 1, 0, 0, 0, 0));
        rows.push_back(mk(32'h3FFFFFFF, 32'h34000000, 1, 0, 0, 0, 0));
        rows.push_back(mk(32'h007FFFFF, 32'h00000001, 1, 0, 0, 0, 0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[n]) offer(rows[n].req, rows[n].typed, rows[n].want);

        // idling phases: none, sender, receiver, both; the first also backs up
        for (int ph = 0; ph < 4; ph++) begin
            send_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 65 : 14) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 65 : 14) : 0;
            run_vectors(130, ph == 0);
        end
        i_valid <= 1'b0;
        cur_typed <= 1'b0;

        while (argmax_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests, %0d vectors checked, %0d NaN moduli skipped",
            req_cnt, res_cnt, nan_cnt);
        $display("directed specials, ties, rounding, overflow; four idling mixes and a backup");
        if (fail_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ===== complex_abs1_argmax.f =====
+incdir+design
design/cabs_pkg.sv
design/cabs_front.sv
design/cabs_queue.sv
design/cabs_back.sv
design/complex_abs1_argmax.sv
dv/complex_abs1_argmax_test.sv
